### sv/mrf_pkg.sv
package mrf_pkg;

  localparam int unsigned DEF_BUFFER_DEPTH = 64;
  localparam int unsigned DEF_MIN_LEN      = 3;
  localparam int unsigned DEF_MAX_LEN      = 8;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned MASK_W  = 6;
  localparam int unsigned FILL_W  = 7;
  // longest window a cell ever compares: largest MIN_LEN plus the mask span
  localparam int unsigned WIN_MAX = 8 + MASK_W - 1;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [MASK_W-1:0] match_mask;
    logic              too_short;
    logic              overflowed;
    logic              last_result;
  } out_beat_t;

  // search token that travels down the row of cells
  typedef struct packed {
    logic                           valid;
    logic                           too_short;
    logic                           last;
    logic [POS_W-1:0]               pos;
    logic [WIN_MAX-1:0][BYTE_W-1:0] pat;
    logic [MASK_W-1:0]              mask;
  } token_t;

  typedef struct packed {
    logic              en;
    logic [POS_W-1:0]  idx;
    logic [BYTE_W-1:0] data;
  } wr_t;

endpackage

### sv/middle_out_repeat_finder.sv
// Loading: one byte beat per cycle; the input stalls from the final byte until the
// last result beat of that run has been taken.
// Search: one token per cycle, while the output is not stalled, enters a row of
// BUFFER_DEPTH cells, which it crosses twice (window fetch, then compare); the
// results then leave through the output register, one per cycle without output stall.
// Reset clears the sequencer, the tokens and the output register; stored bytes are not reset.
module middle_out_repeat_finder #(
  parameter int unsigned BUFFER_DEPTH = mrf_pkg::DEF_BUFFER_DEPTH,
  parameter int unsigned MIN_LEN      = mrf_pkg::DEF_MIN_LEN,
  parameter int unsigned MAX_LEN      = mrf_pkg::DEF_MAX_LEN
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mrf_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mrf_pkg::out_beat_t out_data_o
);
  import mrf_pkg::*;

  logic              adv;
  logic              done;
  wr_t               wr;
  logic [FILL_W-1:0] size;
  logic              ovf;
  token_t            head;
  token_t            tail;

  logic              out_valid_q;
  out_beat_t         out_q;

  // advance the whole row whenever the output register can take a beat
  assign adv  = !out_valid_q || !out_stall_i;
  assign done = out_valid_q && !out_stall_i && out_q.last_result;

  mrf_seq #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .MIN_LEN      (MIN_LEN)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .adv_i      (adv),
    .done_i     (done),
    .wr_o       (wr),
    .size_o     (size),
    .ovf_o      (ovf),
    .head_o     (head)
  );

  mrf_chain #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .MIN_LEN      (MIN_LEN),
    .MAX_LEN      (MAX_LEN)
  ) u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .wr_i   (wr),
    .size_i (size),
    .head_i (head),
    .tail_o (tail)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (adv) begin
      out_valid_q            <= tail.valid;
      out_q.position         <= tail.pos;
      out_q.match_mask       <= tail.mask;
      out_q.too_short        <= tail.too_short;
      out_q.overflowed       <= ovf;
      out_q.last_result      <= tail.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### sv/mrf_cell.sv
module mrf_cell #(
  parameter int unsigned IDX     = 0,
  parameter int unsigned MIN_LEN = mrf_pkg::DEF_MIN_LEN,
  parameter int unsigned MAX_LEN = mrf_pkg::DEF_MAX_LEN
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           adv_i,
  input  mrf_pkg::wr_t                                   wr_i,
  input  logic [mrf_pkg::FILL_W-1:0]                     size_i,
  input  logic [mrf_pkg::WIN_MAX-1:0][mrf_pkg::BYTE_W-1:0] win_i,
  output logic [mrf_pkg::BYTE_W-1:0]                     byte_o,
  input  mrf_pkg::token_t                                fetch_i,
  output mrf_pkg::token_t                                fetch_o,
  input  mrf_pkg::token_t                                cmp_i,
  output mrf_pkg::token_t                                cmp_o
);
  import mrf_pkg::*;

  logic [BYTE_W-1:0]  byte_q;
  token_t             fetch_q, fetch_d;
  token_t             cmp_q, cmp_d;
  logic [WIN_MAX-1:0] eq;
  logic [MASK_W-1:0]  hit;

  function automatic logic [WIN_MAX-1:0] len_mask(input int unsigned len);
    logic [WIN_MAX-1:0] m;
    m = '0;
    for (int unsigned j = 0; j < WIN_MAX; j++) begin
      m[j] = (j < len);
    end
    return m;
  endfunction

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.idx == POS_W'(IDX))) begin
      byte_q <= wr_i.data;
    end
  end

  assign byte_o = byte_q;

  // first pass: the token picks up the window of its own start position
  always_comb begin
    fetch_d = fetch_i;
    if (fetch_i.pos == POS_W'(IDX)) begin
      fetch_d.pat = win_i;
    end
  end

  // second pass: flag each in-run length up to MAX_LEN whose window here equals the pattern, except at own start
  always_comb begin
    cmp_d = cmp_i;
    for (int unsigned j = 0; j < WIN_MAX; j++) begin
      eq[j] = (win_i[j] == cmp_i.pat[j]);
    end
    for (int unsigned k = 0; k < MASK_W; k++) begin
      hit[k] = (&(eq | ~len_mask(MIN_LEN + k)))
            && ((MIN_LEN + k) <= MAX_LEN)
            && ((IDX + MIN_LEN + k) <= 32'(size_i))
            && ((FILL_W'(cmp_i.pos) + FILL_W'(MIN_LEN + k)) <= size_i)
            && (cmp_i.pos != POS_W'(IDX))
            && !cmp_i.too_short;
    end
    cmp_d.mask = cmp_i.mask | hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fetch_q <= '0;
      cmp_q   <= '0;
    end else if (adv_i) begin
      fetch_q <= fetch_d;
      cmp_q   <= cmp_d;
    end
  end

  assign fetch_o = fetch_q;
  assign cmp_o   = cmp_q;

endmodule

### sv/mrf_chain.sv
module mrf_chain #(
  parameter int unsigned BUFFER_DEPTH = mrf_pkg::DEF_BUFFER_DEPTH,
  parameter int unsigned MIN_LEN      = mrf_pkg::DEF_MIN_LEN,
  parameter int unsigned MAX_LEN      = mrf_pkg::DEF_MAX_LEN
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  mrf_pkg::wr_t               wr_i,
  input  logic [mrf_pkg::FILL_W-1:0] size_i,
  input  mrf_pkg::token_t            head_i,
  output mrf_pkg::token_t            tail_o
);
  import mrf_pkg::*;

  token_t            fetch [BUFFER_DEPTH+1];
  token_t            cmp   [BUFFER_DEPTH+1];
  logic [BYTE_W-1:0] bytes [BUFFER_DEPTH];

  assign fetch[0] = head_i;
  // wrap the fetch pass into the compare pass
  assign cmp[0]   = fetch[BUFFER_DEPTH];
  assign tail_o   = cmp[BUFFER_DEPTH];

  for (genvar q = 0; q < BUFFER_DEPTH; q++) begin : g_cell
    wire [WIN_MAX-1:0][BYTE_W-1:0] win;

    for (genvar j = 0; j < WIN_MAX; j++) begin : g_win
      if (q + j < BUFFER_DEPTH) begin : g_in
        assign win[j] = bytes[q+j];
      end else begin : g_out
        assign win[j] = '0;
      end
    end

    mrf_cell #(
      .IDX     (q),
      .MIN_LEN (MIN_LEN),
      .MAX_LEN (MAX_LEN)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv_i),
      .wr_i    (wr_i),
      .size_i  (size_i),
      .win_i   (win),
      .byte_o  (bytes[q]),
      .fetch_i (fetch[q]),
      .fetch_o (fetch[q+1]),
      .cmp_i   (cmp[q]),
      .cmp_o   (cmp[q+1])
    );
  end

endmodule

### sv/mrf_seq.sv
module mrf_seq #(
  parameter int unsigned BUFFER_DEPTH = mrf_pkg::DEF_BUFFER_DEPTH,
  parameter int unsigned MIN_LEN      = mrf_pkg::DEF_MIN_LEN
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  mrf_pkg::in_beat_t          in_data_i,
  output logic                       in_stall_o,
  input  logic                       adv_i,
  input  logic                       done_i,
  output mrf_pkg::wr_t               wr_o,
  output logic [mrf_pkg::FILL_W-1:0] size_o,
  output logic                       ovf_o,
  output mrf_pkg::token_t            head_o
);
  import mrf_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SEARCH,
    ST_DRAIN
  } state_e;

  state_e            state_q, state_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              ovf_q, ovf_d;
  logic [POS_W-1:0]  dist_q, dist_d;
  logic              upper_q, upper_d;

  logic [POS_W-1:0]  mid;
  logic              in_beat;
  logic              short_run;
  logic              has_up;
  logic              at_mid;

  assign mid       = fill_q[FILL_W-1:1];
  assign in_beat   = in_valid_i && (state_q == ST_LOAD);
  assign short_run = (fill_q < FILL_W'(2 * MIN_LEN));
  assign at_mid    = (dist_q == mid);
  // the upper neighbor exists unless it is the middle itself or past the end
  assign has_up    = (dist_q != '0) && (!at_mid || fill_q[0]);

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    ovf_d   = ovf_q;
    dist_d  = dist_q;
    upper_d = upper_q;
    head_o  = '0;
    wr_o.en   = 1'b0;
    wr_o.idx  = fill_q[POS_W-1:0];
    wr_o.data = in_data_i.data_byte;

    unique case (state_q)
      ST_LOAD: begin
        if (in_beat) begin
          if (fill_q < FILL_W'(BUFFER_DEPTH)) begin
            wr_o.en = 1'b1;
            fill_d  = fill_q + FILL_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_data_i.last_byte) begin
            state_d = ST_SEARCH;
            dist_d  = '0;
            upper_d = 1'b0;
          end
        end
      end
      ST_SEARCH: begin
        if (adv_i) begin
          head_o.valid = 1'b1;
          if (short_run) begin
            head_o.too_short = 1'b1;
            head_o.last      = 1'b1;
            state_d          = ST_DRAIN;
          end else if (!upper_q) begin
            head_o.pos = mid - dist_q;
            if (at_mid && !has_up) begin
              head_o.last = 1'b1;
              state_d     = ST_DRAIN;
            end else if (has_up) begin
              upper_d = 1'b1;
            end else begin
              dist_d = dist_q + POS_W'(1);
            end
          end else begin
            head_o.pos = mid + dist_q;
            upper_d    = 1'b0;
            if (at_mid) begin
              head_o.last = 1'b1;
              state_d     = ST_DRAIN;
            end else begin
              dist_d = dist_q + POS_W'(1);
            end
          end
        end
      end
      ST_DRAIN: begin
        // hold the bytes until the final result beat leaves
        if (done_i) begin
          state_d = ST_LOAD;
          fill_d  = '0;
          ovf_d   = 1'b0;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      fill_q  <= '0;
      ovf_q   <= 1'b0;
      dist_q  <= '0;
      upper_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ovf_q   <= ovf_d;
      dist_q  <= dist_d;
      upper_q <= upper_d;
    end
  end

  assign in_stall_o = (state_q != ST_LOAD);
  assign size_o     = fill_q;
  assign ovf_o      = ovf_q;

endmodule

### sv/mrf_checker.sv
module mrf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input mrf_pkg::in_beat_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input mrf_pkg::out_beat_t out_data_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // results only appear while the load side is held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("result beat while input open");

  // a too-short run is one empty, final beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.too_short |->
      out_data_o.last_result && (out_data_o.match_mask == '0)
      && (out_data_o.position == '0))
    else $error("malformed too-short beat");

  // final byte closes the load side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.last_byte |=> in_stall_o)
    else $error("input open after final byte");

  // taking the last result reopens loading with nothing left behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_data_o.last_result |=> !in_stall_o && !out_valid_o)
    else $error("run did not end cleanly");

endmodule

bind middle_out_repeat_finder mrf_checker u_mrf_checker (.*);
